// File: rtl/sdx7_pkg.sv
// Shared types, constants and helper functions for the base-7 Soundex encoder.
// Used by sdx7_update and soundex_base7_encoder; depends on nothing.
package sdx7_pkg;

  localparam int CHAR_W     = 8;
  localparam int LETTER_W   = 5;
  localparam int DIGIT_W    = 17;
  localparam int KEY_W      = DIGIT_W + LETTER_W;
  localparam int CNT_W      = 3;
  localparam int CODE_W     = 3;
  localparam int OUT_DATA_W = 40;  // key and digit value, padded to whole bytes

  localparam logic [CNT_W-1:0]  CODE_DIGITS_RESET = 3'd3;
  localparam logic [CNT_W-1:0]  MAX_DIGITS        = 3'd6;

  localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] ASCII_UPPER_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] ASCII_LOWER_Z = 8'h7A;

  // Decoded character
  typedef struct packed {
    logic                is_letter;
    logic [LETTER_W-1:0] idx;
  } letter_t;

  // What the per-character update hands to the padding multiply
  typedef struct packed {
    logic                invalid;
    logic [LETTER_W-1:0] first;
    logic [DIGIT_W-1:0]  acc;
    logic [CNT_W-1:0]    pad_exp;
  } word_t;

  // Case-folded letter index, or not a letter
  function automatic letter_t letter_of(input logic [CHAR_W-1:0] ch);
    letter_t r;
    logic [CHAR_W-1:0] diff;
    r    = '0;
    diff = '0;
    if (ch inside {[ASCII_UPPER_A:ASCII_UPPER_Z]}) begin
      diff        = ch - ASCII_UPPER_A;
      r.is_letter = 1'b1;
      r.idx       = diff[LETTER_W-1:0];
    end else if (ch inside {[ASCII_LOWER_A:ASCII_LOWER_Z]}) begin
      diff        = ch - ASCII_LOWER_A;
      r.is_letter = 1'b1;
      r.idx       = diff[LETTER_W-1:0];
    end
    return r;
  endfunction

  // Soundex digit code per letter; vowels, H, W and Y give 0
  function automatic logic [CODE_W-1:0] code_of(input logic [LETTER_W-1:0] idx);
    logic [CODE_W-1:0] c;
    case (idx)
      5'd0:  c = 3'd0;  5'd1:  c = 3'd1;  5'd2:  c = 3'd2;  5'd3:  c = 3'd3;
      5'd4:  c = 3'd0;  5'd5:  c = 3'd1;  5'd6:  c = 3'd2;  5'd7:  c = 3'd0;
      5'd8:  c = 3'd0;  5'd9:  c = 3'd2;  5'd10: c = 3'd2;  5'd11: c = 3'd4;
      5'd12: c = 3'd5;  5'd13: c = 3'd5;  5'd14: c = 3'd0;  5'd15: c = 3'd1;
      5'd16: c = 3'd2;  5'd17: c = 3'd6;  5'd18: c = 3'd2;  5'd19: c = 3'd3;
      5'd20: c = 3'd0;  5'd21: c = 3'd1;  5'd22: c = 3'd0;  5'd23: c = 3'd2;
      5'd24: c = 3'd0;  5'd25: c = 3'd2;
      default: c = 3'd0;
    endcase
    return c;
  endfunction

  // Powers of seven used to pad missing digits
  function automatic logic [DIGIT_W-1:0] pow7(input logic [CNT_W-1:0] e);
    logic [DIGIT_W-1:0] p;
    case (e)
      3'd0:    p = 17'd1;
      3'd1:    p = 17'd7;
      3'd2:    p = 17'd49;
      3'd3:    p = 17'd343;
      3'd4:    p = 17'd2401;
      3'd5:    p = 17'd16807;
      3'd6:    p = 17'd117649;
      default: p = 17'd1;
    endcase
    return p;
  endfunction

endpackage

// File: rtl/sdx7_update.sv
// Per-character Soundex state: first letter, prior code, digit accumulator.
// Depends on sdx7_pkg.
module sdx7_update (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,      // stage word advances this cycle
  input  logic [sdx7_pkg::CHAR_W-1:0]   char_in,
  input  logic                          last_in,
  input  logic [sdx7_pkg::CNT_W-1:0]    n_digits,  // effective digit count, 0..6
  output sdx7_pkg::word_t               word_out
);

  logic [sdx7_pkg::LETTER_W-1:0] first_r,   first_nxt;
  logic [sdx7_pkg::CODE_W-1:0]   prior_r,   prior_nxt;
  logic [sdx7_pkg::DIGIT_W-1:0]  acc_r,     acc_nxt;
  logic [sdx7_pkg::CNT_W-1:0]    done_r,    done_nxt;
  logic                          mid_r,     mid_nxt;
  logic                          invalid_r, invalid_nxt;

  sdx7_pkg::letter_t             let_c;
  logic [sdx7_pkg::CODE_W-1:0]   code_c;
  logic [sdx7_pkg::DIGIT_W+2:0]  acc_x7;

  assign let_c  = sdx7_pkg::letter_of(char_in);
  assign code_c = sdx7_pkg::code_of(let_c.idx);
  // acc * 7 + code, as shift and subtract
  assign acc_x7 = {acc_r, 3'b000} - {3'b000, acc_r} + {{sdx7_pkg::DIGIT_W{1'b0}}, code_c};

  // Next state for one character
  always_comb begin
    first_nxt   = first_r;
    prior_nxt   = prior_r;
    acc_nxt     = acc_r;
    done_nxt    = done_r;
    mid_nxt     = mid_r;
    invalid_nxt = invalid_r;
    if (!mid_r) begin
      acc_nxt  = '0;
      done_nxt = '0;
      mid_nxt  = 1'b1;
      if (let_c.is_letter) begin
        first_nxt   = let_c.idx;
        prior_nxt   = code_c;
        invalid_nxt = 1'b0;
      end else begin
        first_nxt   = '0;
        prior_nxt   = '0;
        invalid_nxt = 1'b1;
      end
    end else if (!invalid_r && let_c.is_letter && (done_r < n_digits)) begin
      if ((code_c != '0) && (code_c != prior_r)) begin
        acc_nxt  = acc_x7[sdx7_pkg::DIGIT_W-1:0];
        done_nxt = done_r + 3'd1;
      end
      prior_nxt = code_c;
    end
    if (last_in) begin
      mid_nxt = 1'b0;
    end
  end

  // Word summary for the result stage; padding only when short of digits
  always_comb begin
    word_out.invalid = invalid_nxt;
    word_out.first   = first_nxt;
    word_out.acc     = acc_nxt;
    word_out.pad_exp = (done_nxt < n_digits) ? (n_digits - done_nxt) : '0;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r   <= '0;
      prior_r   <= '0;
      acc_r     <= '0;
      done_r    <= '0;
      mid_r     <= 1'b0;
      invalid_r <= 1'b0;
    end else if (step) begin
      first_r   <= first_nxt;
      prior_r   <= prior_nxt;
      acc_r     <= acc_nxt;
      done_r    <= done_nxt;
      mid_r     <= mid_nxt;
      invalid_r <= invalid_nxt;
    end
  end

endmodule

// File: rtl/soundex_base7_encoder.sv
// Top level of the streaming base-7 Soundex encoder: input stage, padding
// multiply and result register. Depends on sdx7_pkg and sdx7_update.
//
//  channel  | direction | word contents
//  ---------+-----------+-----------------------------------------------
//  in_      | slave     | character per word, tlast on final character
//  out_     | master    | sound_key, digit_value; tuser = bad_head
//  cfg_     | slave     | code_digits (3 bits), always ready
//
// One character per cycle sustained while results are taken; a final character
// waits in the input stage while the result register is full and not taken.
// The result register loads as the final character leaves the input stage.
// rst_n is synchronous, active low; it empties both stages and sets
// code_digits to 3. A stalled result holds only the final-character word in
// the input stage; other characters keep flowing behind a waiting result.
module soundex_base7_encoder (
  input  logic                              clk,
  input  logic                              rst_n,
  // input characters
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [sdx7_pkg::CHAR_W-1:0]       in_tdata,   // [7:0] character
  input  logic                              in_tlast,   // last_char
  // results
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [sdx7_pkg::OUT_DATA_W-1:0]   out_tdata,  // [21:0] sound_key, [38:22] digit_value
  output logic                              out_tuser,  // bad_head
  // configuration
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sdx7_pkg::CNT_W-1:0]        cfg_data    // code_digits
);

  logic [sdx7_pkg::CNT_W-1:0]    digits_r;
  logic [sdx7_pkg::CNT_W-1:0]    n_eff;

  logic                          stg_valid_r;
  logic [sdx7_pkg::CHAR_W-1:0]   stg_char_r;
  logic                          stg_last_r;
  logic                          stg_fire;

  sdx7_pkg::word_t               word_c;
  logic [2*sdx7_pkg::DIGIT_W-1:0] pad_prod;
  logic [sdx7_pkg::DIGIT_W-1:0]  value_c;

  logic                          out_valid_r;
  logic [sdx7_pkg::KEY_W-1:0]    key_r;
  logic [sdx7_pkg::DIGIT_W-1:0]  value_r;
  logic                          bad_r;

  // Configuration register, clamped to six digits on use
  assign cfg_ready = 1'b1;
  assign n_eff     = (digits_r > sdx7_pkg::MAX_DIGITS) ? sdx7_pkg::MAX_DIGITS : digits_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digits_r <= sdx7_pkg::CODE_DIGITS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      digits_r <= cfg_data;
    end
  end

  // Input stage: a final character waits only if the result register is full
  assign stg_fire  = stg_valid_r && (!stg_last_r || !out_valid_r || out_tready);
  assign in_tready = !stg_valid_r || stg_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_tready) begin
      stg_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      stg_char_r <= in_tdata;
      stg_last_r <= in_tlast;
    end
  end

  sdx7_update u_update (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (stg_fire),
    .char_in  (stg_char_r),
    .last_in  (stg_last_r),
    .n_digits (n_eff),
    .word_out (word_c)
  );

  // Zero padding: scale by 7 to the number of missing digits
  assign pad_prod = word_c.acc * sdx7_pkg::pow7(word_c.pad_exp);
  assign value_c  = word_c.invalid ? '0 : pad_prod[sdx7_pkg::DIGIT_W-1:0];

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stg_fire && stg_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_fire && stg_last_r) begin
      value_r <= value_c;
      bad_r   <= word_c.invalid;
      key_r   <= word_c.invalid ? '0 : {value_c, word_c.first};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, value_r, key_r};
  assign out_tuser  = bad_r;

endmodule
